/* sv/cbc_pkg.sv */
package cbc_pkg;

	localparam int IdEntries = 64;
	localparam int CountBits = 16;
	localparam int BytesPerFrame = 8;
	localparam int IdBits = 29;
	localparam int DlcBits = 4;
	localparam int DataBits = 64;
	localparam int CfgBits = 16;

	localparam logic [15:0] MinHistoryReset = 16'd10;
	localparam logic [15:0] MinIdReset = 16'd5;

	typedef enum logic [1:0] {
		REQ_FRAME = 2'd0,
		REQ_QUERY = 2'd1
	} req_t;

	typedef enum logic [2:0] {
		ST_TAKEN = 3'd0,
		ST_DROPPED = 3'd1,
		ST_FOUND = 3'd2,
		ST_UNKNOWN = 3'd3,
		ST_CLEARED = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		CFG_MIN_HISTORY = 1'd0,
		CFG_MIN_ID = 1'd1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEARCH,
		S_SEARCH_WAIT,
		S_ALLOC,
		S_BYTE_RD,
		S_BYTE_WAIT,
		S_BYTE_WR,
		S_TOG_RD,
		S_TOG_WAIT,
		S_TOG_WR,
		S_FINISH,
		S_DONE
	} state_t;

endpackage

/* sv/cbc_ram.sv */
module cbc_ram #(
	parameter int Width = 16,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/can_byte_counter_noise_classifier_unit.sv */
// One request at a time. The sequencer scans the identifier table one entry at a
// time, through a search and a wait state per entry, then walks the eight byte
// positions: per byte one read/update of the byte counters and eight read/update
// steps of the bit toggle counters. Pair and toggle counts go through one shared
// saturating incrementer, the toggle checks through one compare unit. New
// identifiers have their counters zeroed by the walk itself. Statistics live in
// registered-read RAMs. A waiting result holds the input stalled.
module can_byte_counter_noise_classifier_unit #(
	parameter int ID_ENTRIES = cbc_pkg::IdEntries,
	parameter int COUNT_BITS = cbc_pkg::CountBits
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     req_type,
	input  logic [cbc_pkg::IdBits-1:0]     frame_id,
	input  logic [cbc_pkg::DlcBits-1:0]    frame_dlc,
	input  logic [cbc_pkg::DataBits-1:0]   frame_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     status,
	output logic [7:0]                     auto_increment_mask,
	output logic [7:0]                     cyclic_noise_mask,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [cbc_pkg::CfgBits-1:0]    cfg_data
);

	localparam int EB = (ID_ENTRIES > 1) ? $clog2(ID_ENTRIES) : 1;
	localparam int ED = 1 << EB;
	localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};
	localparam int PW = COUNT_BITS + 4;

	cbc_pkg::state_t state_q, state_d;

	logic [15:0] min_hist_q, min_id_q;
	logic [COUNT_BITS-1:0] total_q;
	logic [ID_ENTRIES-1:0] valid_q;
	logic [1:0] req_q;
	logic [cbc_pkg::IdBits-1:0] id_q;
	logic [3:0] dlc_q;
	logic [63:0] data_q;
	logic [EB-1:0] idx_q;
	logic [EB:0] scan_q;
	logic found_q, new_q;
	logic [2:0] byte_q, bit_q;
	logic [2:0] status_q;
	logic [7:0] inc_q, noise_q;
	logic out_valid_q;
	logic [COUNT_BITS-1:0] pair_q, chg_q, step_q;
	logic elig_q;
	logic [63:0] prev_q;
	logic [3:0] plen_q;

	// entry memories
	logic ent_we;
	logic [EB-1:0] ent_waddr, ent_raddr;
	logic [cbc_pkg::IdBits+64+4+COUNT_BITS-1:0] ent_wdata, ent_rdata;
	logic [cbc_pkg::IdBits-1:0] ent_id_rd;
	logic [63:0] ent_pay_rd;
	logic [3:0] ent_len_rd;
	logic [COUNT_BITS-1:0] ent_cnt_rd;

	assign {ent_id_rd, ent_pay_rd, ent_len_rd, ent_cnt_rd} = ent_rdata;

	cbc_ram #(.Width(cbc_pkg::IdBits+64+4+COUNT_BITS), .Depth(ED)) u_ent (
		.clk, .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
		.raddr(ent_raddr), .rdata(ent_rdata)
	);

	// byte counters: pair, change, step
	logic byt_we;
	logic [EB+2:0] byt_addr;
	logic [3*COUNT_BITS-1:0] byt_wdata, byt_rdata;

	cbc_ram #(.Width(3*COUNT_BITS), .Depth(ED*8)) u_byt (
		.clk, .we(byt_we), .waddr(byt_addr), .wdata(byt_wdata),
		.raddr(byt_addr), .rdata(byt_rdata)
	);

	logic tog_we;
	logic [EB+5:0] tog_addr;
	logic [COUNT_BITS-1:0] tog_wdata, tog_rdata;

	cbc_ram #(.Width(COUNT_BITS), .Depth(ED*64)) u_tog (
		.clk, .we(tog_we), .waddr(tog_addr), .wdata(tog_wdata),
		.raddr(tog_addr), .rdata(tog_rdata)
	);

	// shared saturating incrementer and compare unit
	logic [COUNT_BITS-1:0] inc_in, inc_out;
	assign inc_out = (inc_in == CntMax) ? CntMax : inc_in + 1'b1;

	logic [PW-1:0] cmp_a, cmp_b;
	logic cmp_gt;
	assign cmp_gt = cmp_a > cmp_b;

	logic [7:0] prev_b, curr_b, xb, db;
	logic in_span;
	logic [3:0] span;
	assign span = (dlc_q < plen_q) ? dlc_q : plen_q;
	assign in_span = !new_q && ({1'b0, byte_q} < span);
	assign prev_b = prev_q[byte_q*8 +: 8];
	assign curr_b = data_q[byte_q*8 +: 8];
	assign xb = prev_b ^ curr_b;
	assign db = curr_b - prev_b;

	logic [COUNT_BITS-1:0] p_rd, c_rd, s_rd, p_nx, c_nx, s_nx;
	assign {p_rd, c_rd, s_rd} = byt_rdata;

	// change and step counters: separate incrementers beside the shared one
	logic [COUNT_BITS-1:0] c_inc, s_inc;
	assign c_inc = (c_rd == CntMax) ? CntMax : c_rd + 1'b1;
	assign s_inc = (s_rd == CntMax) ? CntMax : s_rd + 1'b1;
	logic step_hit;
	assign step_hit = in_span && xb != 8'd0 && (db == 8'd1 || db == 8'hFF);

	always_comb begin
		case (state_q)
			cbc_pkg::S_BYTE_WR: inc_in = p_rd;
			cbc_pkg::S_TOG_WR: inc_in = tog_rdata;
			cbc_pkg::S_FINISH: inc_in = new_q ? '0 : ent_cnt_rd;
			default: inc_in = ent_cnt_rd;
		endcase
	end

	logic is_frame;
	assign is_frame = (req_q == cbc_pkg::REQ_FRAME);

	// lowest free entry
	logic [EB-1:0] free_idx;
	logic free_ok;
	always_comb begin
		free_idx = '0;
		free_ok = 1'b0;
		for (int i = ID_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = EB'(i);
				free_ok = 1'b1;
			end
		end
	end

	assign in_stall = (state_q != cbc_pkg::S_IDLE) || out_valid_q;
	assign cfg_ready = (state_q == cbc_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign status = status_q;
	assign auto_increment_mask = inc_q;
	assign cyclic_noise_mask = noise_q;

	logic [EB:0] scan_idx_ext;
	assign scan_idx_ext = scan_q;

	always_comb begin
		state_d = state_q;
		ent_raddr = scan_q[EB-1:0];
		ent_we = 1'b0;
		ent_waddr = idx_q;
		ent_wdata = {id_q, data_q, dlc_q, inc_out};
		byt_we = 1'b0;
		byt_addr = {idx_q, byte_q};
		tog_we = 1'b0;
		tog_addr = {idx_q, byte_q, bit_q};
		cmp_a = '0;
		cmp_b = '0;
		p_nx = new_q ? '0 : p_rd;
		c_nx = new_q ? '0 : c_rd;
		s_nx = new_q ? '0 : s_rd;
		tog_wdata = new_q ? '0 : tog_rdata;
		byt_wdata = {p_nx, c_nx, s_nx};
		case (state_q)
			cbc_pkg::S_IDLE: begin
				if (in_valid && !out_valid_q) begin
					state_d = cbc_pkg::S_SEARCH;
				end
			end
			cbc_pkg::S_SEARCH: begin
				if (req_q[1]) begin
					state_d = cbc_pkg::S_DONE;
				end else if (found_q || scan_idx_ext == (EB+1)'(ID_ENTRIES)) begin
					state_d = found_q ? cbc_pkg::S_BYTE_RD
						: (is_frame ? cbc_pkg::S_ALLOC : cbc_pkg::S_DONE);
				end else begin
					state_d = cbc_pkg::S_SEARCH_WAIT;
				end
			end
			cbc_pkg::S_SEARCH_WAIT: state_d = cbc_pkg::S_SEARCH;
			cbc_pkg::S_ALLOC: begin
				state_d = free_ok ? cbc_pkg::S_BYTE_RD : cbc_pkg::S_DONE;
			end
			cbc_pkg::S_BYTE_RD: state_d = cbc_pkg::S_BYTE_WAIT;
			cbc_pkg::S_BYTE_WAIT: state_d = cbc_pkg::S_BYTE_WR;
			cbc_pkg::S_BYTE_WR: begin
				if (is_frame) begin
					byt_we = 1'b1;
					if (in_span) begin
						p_nx = inc_out;
						if (xb != 8'd0) begin
							c_nx = c_inc;
						end
						if (step_hit) begin
							s_nx = s_inc;
						end
					end
					byt_wdata = {p_nx, c_nx, s_nx};
				end
				state_d = cbc_pkg::S_TOG_RD;
			end
			cbc_pkg::S_TOG_RD: state_d = cbc_pkg::S_TOG_WAIT;
			cbc_pkg::S_TOG_WAIT: state_d = cbc_pkg::S_TOG_WR;
			cbc_pkg::S_TOG_WR: begin
				if (is_frame) begin
					tog_we = 1'b1;
					if (in_span && xb[bit_q]) begin
						tog_wdata = inc_out;
					end
				end
				cmp_a = PW'(tog_rdata) * PW'(5);
				cmp_b = PW'(pair_q) * PW'(2);
				if (bit_q == 3'd7) begin
					state_d = (byte_q == 3'd7) ? cbc_pkg::S_FINISH : cbc_pkg::S_BYTE_RD;
				end else begin
					state_d = cbc_pkg::S_TOG_RD;
				end
			end
			cbc_pkg::S_FINISH: begin
				if (is_frame) begin
					ent_we = 1'b1;
					ent_wdata = {id_q, data_q, dlc_q, inc_out};
				end
				state_d = cbc_pkg::S_DONE;
			end
			cbc_pkg::S_DONE: state_d = cbc_pkg::S_IDLE;
			default: state_d = cbc_pkg::S_IDLE;
		endcase
		if (state_q == cbc_pkg::S_FINISH || state_q == cbc_pkg::S_BYTE_RD ||
			state_q == cbc_pkg::S_BYTE_WAIT || state_q == cbc_pkg::S_BYTE_WR ||
			state_q == cbc_pkg::S_TOG_RD || state_q == cbc_pkg::S_TOG_WAIT ||
			state_q == cbc_pkg::S_TOG_WR) begin
			ent_raddr = idx_q;
		end
	end

	logic [PW-1:0] inc_a1, inc_b1, inc_a2, inc_b2;
	assign inc_a1 = PW'(chg_q) * PW'(5);
	assign inc_b1 = PW'(pair_q) * PW'(4);
	assign inc_a2 = PW'(step_q) * PW'(10);
	assign inc_b2 = PW'(chg_q) * PW'(9);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbc_pkg::S_IDLE;
			min_hist_q <= cbc_pkg::MinHistoryReset;
			min_id_q <= cbc_pkg::MinIdReset;
			total_q <= '0;
			valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == cbc_pkg::CFG_MIN_HISTORY) begin
					min_hist_q <= cfg_data;
				end else begin
					min_id_q <= cfg_data;
				end
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == cbc_pkg::S_DONE) begin
				out_valid_q <= 1'b1;
			end
			if (state_q == cbc_pkg::S_SEARCH && req_q[1]) begin
				valid_q <= '0;
				total_q <= '0;
			end
			if (state_q == cbc_pkg::S_SEARCH && !req_q[1] && is_frame &&
				scan_q == '0 && !found_q) begin
				total_q <= (total_q == CntMax) ? CntMax : total_q + 1'b1;
			end
			if (state_q == cbc_pkg::S_ALLOC && free_ok) begin
				valid_q[free_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cbc_pkg::S_IDLE: begin
				if (in_valid && !in_stall) begin
					req_q <= req_type;
					id_q <= frame_id;
					dlc_q <= frame_dlc;
					data_q <= frame_data;
					scan_q <= '0;
					found_q <= 1'b0;
					new_q <= 1'b0;
					byte_q <= '0;
					bit_q <= '0;
					inc_q <= '0;
					noise_q <= '0;
				end
			end
			cbc_pkg::S_SEARCH: begin
				if (req_q[1]) begin
					status_q <= cbc_pkg::ST_CLEARED;
				end else if (!found_q && scan_idx_ext != (EB+1)'(ID_ENTRIES)) begin
					idx_q <= scan_q[EB-1:0];
				end
				if (!found_q && scan_idx_ext == (EB+1)'(ID_ENTRIES) && !is_frame) begin
					status_q <= cbc_pkg::ST_UNKNOWN;
				end
				if (found_q) begin
					status_q <= is_frame ? cbc_pkg::ST_TAKEN : cbc_pkg::ST_FOUND;
					elig_q <= (32'(total_q) >= 32'(min_hist_q)) &&
						(32'(ent_cnt_rd) >= 32'(min_id_q));
					prev_q <= ent_pay_rd;
					plen_q <= ent_len_rd;
				end
			end
			cbc_pkg::S_SEARCH_WAIT: begin
				if (valid_q[idx_q] && ent_id_rd == id_q) begin
					found_q <= 1'b1;
				end else begin
					scan_q <= scan_q + 1'b1;
				end
			end
			cbc_pkg::S_ALLOC: begin
				idx_q <= free_idx;
				new_q <= 1'b1;
				status_q <= free_ok ? cbc_pkg::ST_TAKEN : cbc_pkg::ST_DROPPED;
			end
			cbc_pkg::S_BYTE_WR: begin
				pair_q <= p_rd;
				chg_q <= c_rd;
				step_q <= s_rd;
			end
			cbc_pkg::S_TOG_RD: begin
				if (bit_q == 3'd0 && !is_frame && elig_q && pair_q > COUNT_BITS'(4) &&
					inc_a1 > inc_b1 && inc_a2 > inc_b2) begin
					inc_q[byte_q] <= 1'b1;
				end
			end
			cbc_pkg::S_TOG_WR: begin
				if (!is_frame && elig_q && pair_q >= COUNT_BITS'(4) && cmp_gt) begin
					noise_q[byte_q] <= 1'b1;
				end
				bit_q <= bit_q + 1'b1;
				if (bit_q == 3'd7) begin
					byte_q <= byte_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != cbc_pkg::S_IDLE) |-> in_stall)
		else $error("accept while busy");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cbc_pkg::S_DONE) |=> out_valid)
		else $error("result lost");
	a_clear_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == cbc_pkg::ST_CLEARED) |-> (valid_q == '0 &&
		auto_increment_mask == 8'd0 && cyclic_noise_mask == 8'd0))
		else $error("clear incomplete");
`endif

endmodule
